/* rtl/bmli_pkg.sv */
// ----------------------------------------------------------------------------
// bmli_pkg
// Shared types and constants for the battery monitor / LED indicator unit:
// CSR indexes, register reset values, battery mode codes and fixed-point
// constants for the percent estimate.
// ----------------------------------------------------------------------------
package bmli_pkg;

   typedef enum logic [2:0] {
      CSR_VOLTAGE_GAIN    = 3'd0,
      CSR_CURRENT_ZERO    = 3'd1,
      CSR_CURRENT_GAIN    = 3'd2,
      CSR_IDLE_CURRENT    = 3'd3,
      CSR_TRICKLE_CURRENT = 3'd4,
      CSR_MIN_VOLTAGE     = 3'd5,
      CSR_CHARGE_OFFSET   = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_DISCHARGING = 3'd0,
      MODE_CHARGING    = 3'd1,
      MODE_TRICKLE     = 3'd2,
      MODE_CRITICAL    = 3'd3,
      MODE_ERROR       = 3'd4
   } mode_type;

   localparam int CSR_DATA_W = 20;

   // register reset values
   localparam logic [5:0]  VOLTAGE_GAIN_RST  = 6'd30;
   localparam logic [9:0]  CURRENT_ZERO_RST  = 10'd501;
   localparam logic [9:0]  CURRENT_GAIN_RST  = 10'd333;
   localparam logic [19:0] IDLE_CURRENT_RST  = 20'd1000;
   localparam logic [19:0] TRICKLE_RST       = 20'd3000;
   localparam logic [15:0] MIN_VOLTAGE_RST   = 16'd20000;
   localparam logic [11:0] CHARGE_OFFSET_RST = 12'd900;

   // state reset values
   localparam logic [9:0]  SMOOTH_V_RST = 10'd0;
   localparam logic [9:0]  SMOOTH_I_RST = 10'd512;
   localparam logic [6:0]  CHARGE_FULL  = 7'd100;
   localparam logic [6:0]  CHARGE_EMPTY = 7'd0;

   // floor(x/25) = (x * 83887) >> 21, exact for any 16-bit x
   localparam logic [16:0] DIV25_RECIP = 17'd83887;
   localparam int          DIV25_SHIFT = 21;

   localparam logic [6:0]  CRITICAL_PCT = 7'd20;

   // LED pattern bits: [2] high, [1] mid, [0] low
   localparam logic [2:0]  LED_OFF       = 3'b000;
   localparam logic [2:0]  LED_HIGH      = 3'b100;
   localparam logic [2:0]  LED_HIGH_MID  = 3'b110;
   localparam logic [2:0]  LED_MID       = 3'b010;
   localparam logic [2:0]  LED_MID_LOW   = 3'b011;
   localparam logic [2:0]  LED_LOW       = 3'b001;

endpackage

/* rtl/battery_monitor_led_indicator_unit.sv */
// ----------------------------------------------------------------------------
// battery_monitor_led_indicator_unit
// Sample filter, scaling to mV/mA, battery mode and charge classification,
// indicator LED drive and cutter drive supervision.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 registers, then the response register; rsp_ready
//   stalls hold both. Throughput: 1 item per cycle without such a stall.
//   Stage 1 runs the sample filters and the two scaling multipliers;
//   stage 2 runs the divide-by-25 reciprocal multiply, classification and
//   LED pattern into the response register.
// Reset (synchronous): CSRs to defaults, filters to 0 / 512, mode error,
//   charge 100, LEDs off, drives off, pipeline empty.
module battery_monitor_led_indicator_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [9:0]                        req_voltage_sample,
   input  logic [9:0]                        req_current_sample,
   input  logic                              req_left_check_level,
   input  logic                              req_right_check_level,
   input  logic                              req_left_request,
   input  logic                              req_right_request,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_voltage_mv,
   output logic signed [20:0]                rsp_current_ma,
   output logic [2:0]                        rsp_battery_mode,
   output logic [6:0]                        rsp_charge_percent,
   output logic                              rsp_led_high,
   output logic                              rsp_led_mid,
   output logic                              rsp_led_low,
   output logic                              rsp_left_running,
   output logic                              rsp_right_running,
   output logic                              rsp_left_drive,
   output logic                              rsp_right_drive,
   // configuration
   input  logic                              csr_write_en,
   input  bmli_pkg::csr_index_type           csr_index,
   input  logic [bmli_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bmli_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic [5:0]  voltage_gain_ff;
   logic [9:0]  current_zero_ff;
   logic [9:0]  current_gain_ff;
   logic [19:0] idle_current_ff;
   logic [19:0] trickle_current_ff;
   logic [15:0] min_voltage_ff;
   logic [11:0] charge_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_gain_ff    <= VOLTAGE_GAIN_RST;
         current_zero_ff    <= CURRENT_ZERO_RST;
         current_gain_ff    <= CURRENT_GAIN_RST;
         idle_current_ff    <= IDLE_CURRENT_RST;
         trickle_current_ff <= TRICKLE_RST;
         min_voltage_ff     <= MIN_VOLTAGE_RST;
         charge_offset_ff   <= CHARGE_OFFSET_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VOLTAGE_GAIN:    voltage_gain_ff    <= csr_wdata[5:0];
            CSR_CURRENT_ZERO:    current_zero_ff    <= csr_wdata[9:0];
            CSR_CURRENT_GAIN:    current_gain_ff    <= csr_wdata[9:0];
            CSR_IDLE_CURRENT:    idle_current_ff    <= csr_wdata[19:0];
            CSR_TRICKLE_CURRENT: trickle_current_ff <= csr_wdata[19:0];
            CSR_MIN_VOLTAGE:     min_voltage_ff     <= csr_wdata[15:0];
            CSR_CHARGE_OFFSET:   charge_offset_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- flow control
   logic s1_valid_ff;
   logic out_valid_ff;
   logic s2_adv;
   logic req_xfer;
   logic s2_load;

   assign s2_adv    = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_adv;
   assign req_xfer  = req_valid && req_ready;
   assign s2_load   = s1_valid_ff && s2_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready)
            s1_valid_ff <= req_valid;
         if (s2_adv)
            out_valid_ff <= s1_valid_ff;
      end
   end

   // ------------------------------------------------ stage 1: filter/scale
   logic [9:0]  smooth_v_ff, smooth_v_in;
   logic [9:0]  smooth_i_ff, smooth_i_in;
   logic        phase_ff, phase_in;
   logic        left_drive_ff, left_drive_in;
   logic        right_drive_ff, right_drive_in;
   logic [11:0] filt_v_sum, filt_i_sum;
   logic signed [10:0] cur_offset;
   logic signed [21:0] cur_prod;

   // stage 1 -> stage 2 payload
   logic               s1_cmd_ff;
   logic [15:0]        s1_vmv_ff;
   logic signed [20:0] s1_ima_ff;
   logic               s1_phase_ff;
   logic               s1_lrun_ff, s1_rrun_ff;

   // (12*s + 4*p)/16 == (3*s + p)/4
   assign filt_v_sum = 12'(3 * req_voltage_sample) + {2'b00, smooth_v_ff};
   assign filt_i_sum = 12'(3 * req_current_sample) + {2'b00, smooth_i_ff};

   always_comb begin
      smooth_v_in    = smooth_v_ff;
      smooth_i_in    = smooth_i_ff;
      phase_in       = phase_ff;
      left_drive_in  = left_drive_ff;
      right_drive_in = right_drive_ff;
      if (req_cmd) begin
         left_drive_in  = req_left_request;
         right_drive_in = req_right_request;
      end else begin
         smooth_v_in    = filt_v_sum[11:2];
         smooth_i_in    = filt_i_sum[11:2];
         phase_in       = !phase_ff;
         left_drive_in  = left_drive_ff && !req_left_check_level;
         right_drive_in = right_drive_ff && !req_right_check_level;
      end
   end

   assign cur_offset = $signed({1'b0, smooth_i_in}) - $signed({1'b0, current_zero_ff});
   assign cur_prod   = $signed({1'b0, current_gain_ff}) * cur_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_v_ff    <= SMOOTH_V_RST;
         smooth_i_ff    <= SMOOTH_I_RST;
         phase_ff       <= 1'b0;
         left_drive_ff  <= 1'b0;
         right_drive_ff <= 1'b0;
      end else if (req_xfer) begin
         smooth_v_ff    <= smooth_v_in;
         smooth_i_ff    <= smooth_i_in;
         phase_ff       <= phase_in;
         left_drive_ff  <= left_drive_in;
         right_drive_ff <= right_drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff   <= req_cmd;
         s1_vmv_ff   <= 16'(smooth_v_in * voltage_gain_ff);
         s1_ima_ff   <= cur_prod[20:0];
         s1_phase_ff <= phase_in;
         s1_lrun_ff  <= !req_left_check_level;
         s1_rrun_ff  <= !req_right_check_level;
      end
   end

   // ---------------------------------------- stage 2: classify, LEDs, output
   mode_type    mode_ff, mode_in;
   logic [6:0]  charge_ff, charge_in;
   logic [2:0]  led_ff, led_in;
   logic [20:0] cur_mag;
   logic [32:0] div_prod;
   logic [11:0] v_div25;
   logic signed [12:0] pct_raw;
   logic [6:0]  pct_sat;

   logic [15:0]        out_vmv_ff;
   logic signed [20:0] out_ima_ff;
   logic               out_lrun_ff, out_rrun_ff;
   logic               out_ldrive_ff, out_rdrive_ff;

   function automatic logic [2:0] level_pattern(input logic [6:0] charge);
      logic [2:0] pat;
      if (charge >= 7'd80)      pat = LED_HIGH;
      else if (charge >= 7'd60) pat = LED_HIGH_MID;
      else if (charge >= 7'd40) pat = LED_MID;
      else if (charge >= 7'd20) pat = LED_MID_LOW;
      else                      pat = LED_LOW;
      return pat;
   endfunction

   assign cur_mag  = s1_ima_ff[20] ? 21'(-s1_ima_ff) : s1_ima_ff;
   assign div_prod = s1_vmv_ff * DIV25_RECIP;
   assign v_div25  = div_prod[32:DIV25_SHIFT];
   assign pct_raw  = $signed({1'b0, v_div25}) - $signed({1'b0, charge_offset_ff});

   always_comb begin
      if (pct_raw < 0)
         pct_sat = CHARGE_EMPTY;
      else if (pct_raw > 13'sd100)
         pct_sat = CHARGE_FULL;
      else
         pct_sat = pct_raw[6:0];
   end

   always_comb begin
      mode_in   = mode_ff;
      charge_in = charge_ff;
      led_in    = led_ff;
      if (!s1_cmd_ff) begin
         if (cur_mag <= {1'b0, idle_current_ff}) begin
            mode_in = MODE_ERROR;            // battery disconnected, charge held
         end else if (s1_vmv_ff < min_voltage_ff) begin
            mode_in   = MODE_ERROR;
            charge_in = CHARGE_EMPTY;
         end else if (!s1_ima_ff[20]) begin
            charge_in = CHARGE_FULL;
            mode_in   = (s1_ima_ff[19:0] < trickle_current_ff) ? MODE_TRICKLE
                                                               : MODE_CHARGING;
         end else begin
            charge_in = pct_sat;
            mode_in   = (pct_sat < CRITICAL_PCT) ? MODE_CRITICAL : MODE_DISCHARGING;
         end

         case (mode_in)
            MODE_CHARGING:    led_in = s1_phase_ff ? LED_HIGH_MID : LED_OFF;
            MODE_TRICKLE:     led_in = s1_phase_ff ? LED_HIGH : LED_OFF;
            MODE_CRITICAL:    led_in = s1_phase_ff ? LED_LOW : LED_OFF;
            MODE_DISCHARGING: led_in = level_pattern(charge_in);
            default:          led_in = LED_OFF;
         endcase
      end
   end

   // mode/charge/LED registers are both the held state and the response fields
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ERROR;
         charge_ff <= CHARGE_FULL;
         led_ff    <= LED_OFF;
      end else if (s2_load) begin
         mode_ff   <= mode_in;
         charge_ff <= charge_in;
         led_ff    <= led_in;
      end
   end

   // stage 1 always holds the newest accepted item, so the live drive state
   // is the one that belongs to it
   always_ff @(posedge clock) begin
      if (s2_load) begin
         out_vmv_ff    <= s1_vmv_ff;
         out_ima_ff    <= s1_ima_ff;
         out_lrun_ff   <= s1_lrun_ff;
         out_rrun_ff   <= s1_rrun_ff;
         out_ldrive_ff <= left_drive_ff;
         out_rdrive_ff <= right_drive_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_voltage_mv     = out_vmv_ff;
   assign rsp_current_ma     = out_ima_ff;
   assign rsp_battery_mode   = mode_ff;
   assign rsp_charge_percent = charge_ff;
   assign rsp_led_high       = led_ff[2];
   assign rsp_led_mid        = led_ff[1];
   assign rsp_led_low        = led_ff[0];
   assign rsp_left_running   = out_lrun_ff;
   assign rsp_right_running  = out_rrun_ff;
   assign rsp_left_drive     = out_ldrive_ff;
   assign rsp_right_drive    = out_rdrive_ff;

endmodule
